@@ rtl/quaternion_vector_rotate_defines.svh @@
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// same-cycle implication
`define QVR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qvr check failed");

// next-cycle implication
`define QVR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qvr check failed");

`endif

@@ rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
package qvr_pkg;
	// stages ahead of the divider: products, sums, products, sums, magnitude, range check
	localparam int PRE_STAGES = 6;
	localparam int NUM_COMP = 3;
endpackage

@@ rtl/quaternion_vector_rotate.sv @@
`timescale 1ns / 1ps
// channel | signals                                        | accept
// in      | in_valid, in_stall, vec_x/y/z, quat_w/x/y/z    | in_valid & !in_stall
// out     | out_valid, out_stall, out_x/y/z, degenerate    | out_valid & !out_stall
// One item per cycle while in_stall is low. The pipeline has six arithmetic stages, a
// restoring divider of VEC_WIDTH - 1 stages (one quotient bit each), one output stage.
// Reset clears the stage valid bits only.
// Each full stage holds while the stage after it is full and stalled, so bubbles are
// squeezed out and in_stall rises only when every stage is full.
module quaternion_vector_rotate import qvr_pkg::*; #(
	parameter int VEC_WIDTH  = 24,
	parameter int QUAT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [VEC_WIDTH-1:0]  vec_x,
	input  logic signed [VEC_WIDTH-1:0]  vec_y,
	input  logic signed [VEC_WIDTH-1:0]  vec_z,
	input  logic signed [QUAT_WIDTH-1:0] quat_w,
	input  logic signed [QUAT_WIDTH-1:0] quat_x,
	input  logic signed [QUAT_WIDTH-1:0] quat_y,
	input  logic signed [QUAT_WIDTH-1:0] quat_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [VEC_WIDTH-1:0]  out_x,
	output logic signed [VEC_WIDTH-1:0]  out_y,
	output logic signed [VEC_WIDTH-1:0]  out_z,
	output logic                        degenerate
);
	localparam int VW   = VEC_WIDTH;
	localparam int QW   = QUAT_WIDTH;
	localparam int PW   = 2 * QW;
	localparam int SW   = 2 * QW + 2;
	localparam int UVW  = QW + VW;
	localparam int DW   = QW + VW + 2;
	localparam int D2W  = DW + 1;
	localparam int CW   = QW + VW + 1;
	localparam int W2W  = QW + 1;
	localparam int NW   = 2 * QW + VW + 6;
	localparam int XW   = NW + 2;
	localparam int QTW  = VW - 1;
	localparam int NDIV = VW - 1;
	localparam int L    = PRE_STAGES + NDIV + 1;

	logic [L-1:0] v_q;
	logic [L:0]   en;

	always_comb begin
		en[L] = ~out_stall;
		for (int k = L - 1; k >= 0; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	assign in_stall  = ~en[0];
	assign out_valid = v_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < L; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	logic signed [VW-1:0] vin [NUM_COMP];
	logic signed [QW-1:0] uin [NUM_COMP];
	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;
	assign uin[0] = quat_x;
	assign uin[1] = quat_y;
	assign uin[2] = quat_z;

	// stage 1: first products
	logic signed [VW-1:0]  vec_s1 [NUM_COMP];
	logic signed [QW-1:0]  u_s1   [NUM_COMP];
	logic signed [QW-1:0]  w_s1;
	logic signed [PW-1:0]  ww_s1;
	logic signed [PW-1:0]  uu_s1  [NUM_COMP];
	logic signed [UVW-1:0] dot_s1 [NUM_COMP];
	logic signed [UVW-1:0] crp_s1 [NUM_COMP];
	logic signed [UVW-1:0] crn_s1 [NUM_COMP];

	// stage 2: norm, difference, dot, cross
	logic signed [VW-1:0]  vec_s2 [NUM_COMP];
	logic signed [QW-1:0]  u_s2   [NUM_COMP];
	logic signed [SW-1:0]  n_s2;
	logic signed [SW-1:0]  s_s2;
	logic signed [D2W-1:0] d2_s2;
	logic signed [W2W-1:0] w2_s2;
	logic signed [CW-1:0]  cr_s2  [NUM_COMP];

	// stage 3: numerator terms
	logic signed [SW-1:0]      n_s3;
	logic signed [SW+VW-1:0]   ps_s3 [NUM_COMP];
	logic signed [D2W+QW-1:0]  pd_s3 [NUM_COMP];
	logic signed [W2W+CW-1:0]  pw_s3 [NUM_COMP];

	// stage 4: numerators
	logic signed [SW-1:0] n_s4;
	logic signed [NW-1:0] num_s4 [NUM_COMP];

	// stage 5: rounding dividend
	logic [XW-1:0]        x_s5   [NUM_COMP];
	logic [NUM_COMP-1:0]  neg_s5;
	logic [XW-1:0]        dv_s5;
	logic                 dg_s5;

	// stage 6 and divider stages, index 0 is stage 6
	logic [XW-1:0]        rem_sd [NDIV+1][NUM_COMP];
	logic [QTW-1:0]       qt_sd  [NDIV+1][NUM_COMP];
	logic [NUM_COMP-1:0]  sat_sd [NDIV+1];
	logic [NUM_COMP-1:0]  neg_sd [NDIV+1];
	logic [XW-1:0]        dv_sd  [NDIV+1];
	logic                 dg_sd  [NDIV+1];

	// output stage
	logic signed [VW-1:0] res_so [NUM_COMP];
	logic                 dg_so;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			w_s1  <= quat_w;
			ww_s1 <= quat_w * quat_w;
			for (int c = 0; c < NUM_COMP; c++) begin
				vec_s1[c] <= vin[c];
				u_s1[c]   <= uin[c];
				uu_s1[c]  <= uin[c] * uin[c];
				dot_s1[c] <= UVW'(uin[c]) * UVW'(vin[c]);
				crp_s1[c] <= UVW'(uin[(c+1)%3]) * UVW'(vin[(c+2)%3]);
				crn_s1[c] <= UVW'(uin[(c+2)%3]) * UVW'(vin[(c+1)%3]);
			end
		end
		if (en[1]) begin
			n_s2  <= SW'(ww_s1) + SW'(uu_s1[0]) + SW'(uu_s1[1]) + SW'(uu_s1[2]);
			s_s2  <= SW'(ww_s1) - SW'(uu_s1[0]) - SW'(uu_s1[1]) - SW'(uu_s1[2]);
			d2_s2 <= (D2W'(dot_s1[0]) + D2W'(dot_s1[1]) + D2W'(dot_s1[2])) <<< 1;
			w2_s2 <= W2W'(w_s1) <<< 1;
			for (int c = 0; c < NUM_COMP; c++) begin
				vec_s2[c] <= vec_s1[c];
				u_s2[c]   <= u_s1[c];
				cr_s2[c]  <= CW'(crp_s1[c]) - CW'(crn_s1[c]);
			end
		end
		if (en[2]) begin
			n_s3 <= n_s2;
			for (int c = 0; c < NUM_COMP; c++) begin
				ps_s3[c] <= (SW+VW)'(s_s2) * (SW+VW)'(vec_s2[c]);
				pd_s3[c] <= (D2W+QW)'(d2_s2) * (D2W+QW)'(u_s2[c]);
				pw_s3[c] <= (W2W+CW)'(w2_s2) * (W2W+CW)'(cr_s2[c]);
			end
		end
		if (en[3]) begin
			n_s4 <= n_s3;
			for (int c = 0; c < NUM_COMP; c++) begin
				num_s4[c] <= NW'(ps_s3[c]) + NW'(pd_s3[c]) + NW'(pw_s3[c]);
			end
		end
		if (en[4]) begin
			dv_s5 <= XW'(n_s4[SW-2:0]) << 1;
			dg_s5 <= (n_s4 == '0);
			for (int c = 0; c < NUM_COMP; c++) begin
				neg_s5[c] <= num_s4[c][NW-1];
				x_s5[c]   <= (XW'(num_s4[c][NW-1] ? -num_s4[c] : num_s4[c]) << 1)
					+ XW'(n_s4[SW-2:0]);
			end
		end
		if (en[5]) begin
			dv_sd[0]  <= dv_s5;
			dg_sd[0]  <= dg_s5;
			neg_sd[0] <= neg_s5;
			for (int c = 0; c < NUM_COMP; c++) begin
				rem_sd[0][c] <= x_s5[c];
				qt_sd[0][c]  <= '0;
				sat_sd[0][c] <= (x_s5[c] >= (dv_s5 << QTW));
			end
		end
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		localparam int SH = NDIV - 1 - j;
		logic [XW-1:0] trial [NUM_COMP];
		always_comb begin
			for (int c = 0; c < NUM_COMP; c++) begin
				trial[c] = dv_sd[j] << SH;
			end
		end
		always_ff @(posedge clk) begin
			if (en[PRE_STAGES + j]) begin
				dv_sd[j+1]  <= dv_sd[j];
				dg_sd[j+1]  <= dg_sd[j];
				neg_sd[j+1] <= neg_sd[j];
				sat_sd[j+1] <= sat_sd[j];
				for (int c = 0; c < NUM_COMP; c++) begin
					if (rem_sd[j][c] >= trial[c]) begin
						rem_sd[j+1][c] <= rem_sd[j][c] - trial[c];
						qt_sd[j+1][c]  <= qt_sd[j][c] | (QTW'(1) << SH);
					end else begin
						rem_sd[j+1][c] <= rem_sd[j][c];
						qt_sd[j+1][c]  <= qt_sd[j][c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[L-1]) begin
			dg_so <= dg_sd[NDIV];
			for (int c = 0; c < NUM_COMP; c++) begin
				if (dg_sd[NDIV]) begin
					res_so[c] <= '0;
				end else if (sat_sd[NDIV][c]) begin
					res_so[c] <= neg_sd[NDIV][c] ? {1'b1, {QTW{1'b0}}} : {1'b0, {QTW{1'b1}}};
				end else if (neg_sd[NDIV][c]) begin
					res_so[c] <= -$signed({1'b0, qt_sd[NDIV][c]});
				end else begin
					res_so[c] <= $signed({1'b0, qt_sd[NDIV][c]});
				end
			end
		end
	end

	assign out_x      = res_so[0];
	assign out_y      = res_so[1];
	assign out_z      = res_so[2];
	assign degenerate = dg_so;
endmodule

@@ rtl/qvr_checker.sv @@
`timescale 1ns / 1ps
`include "quaternion_vector_rotate_defines.svh"
module qvr_checker #(
	parameter int VEC_WIDTH = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [VEC_WIDTH-1:0] out_x,
	input logic [VEC_WIDTH-1:0] out_y,
	input logic [VEC_WIDTH-1:0] out_z,
	input logic                 degenerate
);
	// degenerate items carry a zero vector
	`QVR_ASSERT_NOW(a_degen_zero, out_valid && degenerate,
		out_x == '0 && out_y == '0 && out_z == '0)
	// back pressure only reaches the input through a stalled output
	`QVR_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall)
	// an empty output stage never holds off the input
	`QVR_ASSERT_NOW(a_empty_ready, !out_valid, !in_stall)
	// a stalled result holds
	`QVR_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z)
		&& $stable(degenerate))
endmodule

bind quaternion_vector_rotate qvr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_qvr_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_x(out_x), .out_y(out_y),
	.out_z(out_z), .degenerate(degenerate)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
	localparam int VW = 24;
	localparam int QW = 16;
	localparam int LATENCY = VW + 6;
	localparam int N_ITEMS = 850;
	localparam longint LIMIT = 400000;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [QW-1:0] quat_t;
	typedef struct packed {
		vec_t x;
		vec_t y;
		vec_t z;
		logic degen;
	} rot_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	vec_t vec_x, vec_y, vec_z, out_x, out_y, out_z;
	quat_t quat_w, quat_x, quat_y, quat_z;
	logic degenerate;
	int errors = 0;
	longint cycles = 0;
	bit hold_out = 0;
	bit calm = 0;

	quaternion_vector_rotate #(.VEC_WIDTH(VW), .QUAT_WIDTH(QW)) dut (.*);

	task automatic report(string what, logic signed [VW-1:0] got, logic signed [VW-1:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic vec_t round_sat(logic signed [127:0] num, logic signed [127:0] n);
		logic signed [127:0] mag, q;
		mag = num < 0 ? -num : num;
		q = (2 * mag + n) / (2 * n);
		if (num < 0) return q >= (128'sd1 <<< (VW - 1)) ? vec_t'(1 << (VW - 1)) : vec_t'(-q);
		return q >= (128'sd1 <<< (VW - 1)) ? vec_t'((1 << (VW - 1)) - 1) : vec_t'(q);
	endfunction

	function automatic rot_t rotate(vec_t vx, vec_t vy, vec_t vz,
			quat_t qw, quat_t qx, quat_t qy, quat_t qz);
		logic signed [127:0] x, y, z, w, a, b, c, ww, uu, n, s, d2, cx, cy, cz;
		rot_t r;
		x = vx; y = vy; z = vz; w = qw; a = qx; b = qy; c = qz;
		ww = w * w;
		uu = a * a + b * b + c * c;
		n = ww + uu;
		if (n == 0) return '{x: '0, y: '0, z: '0, degen: 1'b1};
		s = ww - uu;
		d2 = 2 * (a * x + b * y + c * z);
		cx = b * z - c * y;
		cy = c * x - a * z;
		cz = a * y - b * x;
		r.x = round_sat(s * x + d2 * a + 2 * w * cx, n);
		r.y = round_sat(s * y + d2 * b + 2 * w * cy, n);
		r.z = round_sat(s * z + d2 * c + 2 * w * cz, n);
		r.degen = 1'b0;
		return r;
	endfunction

	class rotation_board;
		rot_t pending[$];
		function void note_input(vec_t vx, vec_t vy, vec_t vz,
				quat_t qw, quat_t qx, quat_t qy, quat_t qz);
			pending.push_back(rotate(vx, vy, vz, qw, qx, qy, qz));
		endfunction
		task check_result(rot_t got);
			rot_t want;
			if (pending.size() == 0) begin
				$display("result with nothing pending");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) report("out_x", got.x, want.x);
			if (got.y !== want.y) report("out_y", got.y, want.y);
			if (got.z !== want.z) report("out_z", got.z, want.z);
			if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
		endtask
	endclass

	rotation_board board = new();

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && in_valid && !in_stall)
			board.note_input(vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z);

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_result('{x: out_x, y: out_y, z: out_z, degen: degenerate});

	always @(posedge clk)
		out_stall <= hold_out || (!calm && $urandom_range(99) < 9);

	function automatic vec_t rand_vec(int kind);
		case (kind)
			0: return vec_t'($urandom);
			1: return vec_t'($signed($urandom_range(8000)) - 4000);
			default: return $urandom_range(1) ? vec_t'(1 << (VW - 1)) : vec_t'((1 << (VW - 1)) - 1);
		endcase
	endfunction

	function automatic quat_t rand_quat(int kind);
		case (kind)
			0: return quat_t'($urandom);
			1: return quat_t'($signed($urandom_range(6)) - 3);
			default: return $urandom_range(1) ? quat_t'(1 << (QW - 1)) : quat_t'((1 << (QW - 1)) - 1);
		endcase
	endfunction

	task automatic send(vec_t vx, vec_t vy, vec_t vz, quat_t qw, quat_t qx, quat_t qy, quat_t qz);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vec_x <= vx; vec_y <= vy; vec_z <= vz;
		quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_random();
		int vk, qk;
		vk = $urandom_range(9) < 7 ? 0 : $urandom_range(2);
		qk = $urandom_range(9) < 7 ? 0 : $urandom_range(2);
		send(rand_vec(vk), rand_vec(vk), rand_vec(vk),
			($urandom_range(39) == 0) ? quat_t'(0) : rand_quat(qk),
			($urandom_range(39) == 0) ? quat_t'(0) : rand_quat(qk),
			rand_quat(qk), rand_quat(qk));
	endtask

	localparam vec_t VMAX = (1 << (VW - 1)) - 1;
	localparam vec_t VMIN = 1 << (VW - 1);
	localparam quat_t QMAX = (1 << (QW - 1)) - 1;
	localparam quat_t QMIN = 1 << (QW - 1);
	localparam quat_t ONE = 1 << (QW - 2);

	initial begin
		arst_n = 0;
		in_valid = 0;
		out_stall = 0;
		{vec_x, vec_y, vec_z} = '0;
		{quat_w, quat_x, quat_y, quat_z} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		send(100, -200, 300, 0, 0, 0, 0);
		send(VMAX, VMIN, VMAX, 0, 0, 0, 0);
		send(4096, 0, 0, ONE, 0, 0, 0);
		send(VMAX, VMIN, 1, ONE, 0, 0, 0);
		send(4096, 8192, -4096, 0, ONE, 0, 0);
		send(4096, 8192, -4096, 0, 0, ONE, 0);
		send(4096, 8192, -4096, 0, 0, 0, ONE);
		send(VMAX, VMAX, VMAX, 11585, 11585, 0, 0);
		send(VMAX, VMAX, VMAX, ONE, ONE, ONE, ONE);
		send(VMIN, VMIN, VMIN, QMIN, QMIN, QMIN, QMIN);
		send(VMAX, VMIN, VMAX, QMAX, QMIN, QMAX, QMIN);
		send(VMIN, VMAX, VMIN, QMIN, QMAX, QMIN, QMAX);
		send(-1, -1, -1, 1, 0, 0, 0);
		send(1, 1, 1, 0, 1, 1, 0);
		send(3, -3, 5, 1, 1, 1, 1);
		send(VMAX, 0, 0, 0, 1, 1, 1);
		send(0, 0, VMIN, -1, 0, 0, 0);
		send(-1, -1, -1, -1, -1, -1, -1);
		drain();
		// back-pressure fill
		hold_out = 1;
		fork
			begin repeat (200) @(posedge clk); hold_out = 0; end
			repeat (80) send_random();
		join
		drain();
		calm = 1;
		repeat (150) send_random();
		calm = 0;
		for (int i = 0; i < 600; i++) begin
			send_random();
			if (i == 300) drain();
		end
		drain();
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
